// File: design/periodic_task_tick_table_unit_defines.svh
// assertion macros for the periodic tick table checker
`ifndef PERIODIC_TASK_TICK_TABLE_UNIT_DEFINES_SVH
`define PERIODIC_TASK_TICK_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PTT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PTT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ptt_pkg.sv
// shared constants, types and codes of the periodic tick table
package ptt_pkg;

	localparam int NUM_SLOTS    = 8;
	localparam int PERIOD_WIDTH = 16;

	localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int COUNT_W = $clog2(NUM_SLOTS + 1);

	// fixed field widths of the channels
	localparam int PERIOD_IN_W = 16;
	localparam int SLOT_IDX_W  = 3;
	localparam int FIRE_W      = 8;
	localparam int TASK_CNT_W  = 4;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                    we_rem;
		logic                    we_per;
		logic [SLOT_W-1:0]       addr;
		logic [PERIOD_WIDTH-1:0] rem_data;
		logic [PERIOD_WIDTH-1:0] per_data;
	} store_ctrl_t;

	typedef struct packed {
		logic                 accepted;
		logic [SLOT_W-1:0]    slot;
		logic [NUM_SLOTS-1:0] fired;
		logic [COUNT_W-1:0]   count;
	} result_t;

endpackage

// File: design/ptt_in_if.sv
// request channel: operation and period word
interface ptt_in_if import ptt_pkg::*;;
	logic                   valid;
	logic                   ready;
	logic                   operation;
	logic [PERIOD_IN_W-1:0] period_ticks;

	modport source (output valid, output operation, output period_ticks, input ready);
	modport sink   (input valid, input operation, input period_ticks, output ready);
endinterface

// File: design/ptt_out_if.sv
// response channel: add result, fire mask and task count word
interface ptt_out_if import ptt_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic                  accepted;
	logic [SLOT_IDX_W-1:0] slot_index;
	logic [FIRE_W-1:0]     fire_mask;
	logic [TASK_CNT_W-1:0] task_count;

	modport source (output valid, output accepted, output slot_index, output fire_mask,
		output task_count, input ready);
	modport sink   (input valid, input accepted, input slot_index, input fire_mask,
		input task_count, output ready);
endinterface

// File: design/ptt_count_unit.sv
// shared countdown unit: zero detect, decrement or reload
module ptt_count_unit import ptt_pkg::*; (
	input  logic [PERIOD_WIDTH-1:0] rem,
	input  logic [PERIOD_WIDTH-1:0] per,
	output logic                    fire,
	output logic [PERIOD_WIDTH-1:0] next
);

	assign fire = (rem == '0);
	assign next = fire ? (per - PERIOD_WIDTH'(1)) : (rem - PERIOD_WIDTH'(1));

endmodule

// File: design/ptt_slot_store.sv
// period and remaining-count registers of the slots
module ptt_slot_store import ptt_pkg::*; (
	input  logic                    clk,
	input  store_ctrl_t             ctrl,
	output logic [PERIOD_WIDTH-1:0] rd_rem,
	output logic [PERIOD_WIDTH-1:0] rd_per
);

	logic [PERIOD_WIDTH-1:0] rem_q [NUM_SLOTS];
	logic [PERIOD_WIDTH-1:0] per_q [NUM_SLOTS];

	always_ff @(posedge clk) begin
		if (ctrl.we_rem) begin
			rem_q[ctrl.addr] <= ctrl.rem_data;
		end
		if (ctrl.we_per) begin
			per_q[ctrl.addr] <= ctrl.per_data;
		end
	end

	assign rd_rem = rem_q[ctrl.addr];
	assign rd_per = per_q[ctrl.addr];

endmodule

// File: design/ptt_seq.sv
// sequencer: takes a word, walks the occupied slots, builds the result
module ptt_seq import ptt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_op,
	input  logic [PERIOD_IN_W-1:0]  in_period,
	output logic                    in_ready,
	input  logic                    res_free,
	output logic                    res_valid,
	output result_t                 res,
	output store_ctrl_t             ctrl,
	input  logic [PERIOD_WIDTH-1:0] rd_rem,
	input  logic [PERIOD_WIDTH-1:0] rd_per,
	output logic [PERIOD_WIDTH-1:0] unit_rem,
	output logic [PERIOD_WIDTH-1:0] unit_per,
	input  logic                    unit_fire,
	input  logic [PERIOD_WIDTH-1:0] unit_next
);

	state_t                  state_q, state_d;
	logic [COUNT_W-1:0]      count_q;
	logic [SLOT_W-1:0]       idx_q;
	logic [NUM_SLOTS-1:0]    fired_q;
	logic                    op_q;
	logic [PERIOD_WIDTH-1:0] period_q;

	logic take;
	logic full;
	logic last;
	logic add_ok;
	logic commit;

	assign full   = (count_q == COUNT_W'(NUM_SLOTS));
	assign last   = ((COUNT_W'(idx_q) + COUNT_W'(1)) == count_q);
	assign add_ok = (op_q == OP_ADD) && !full && (period_q != '0);

	// a new add reuses the unit as a reload from a zero count
	assign unit_rem = (state_q == ST_SCAN) ? rd_rem : '0;
	assign unit_per = (state_q == ST_SCAN) ? rd_per : period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		take      = 1'b0;
		res_valid = 1'b0;
		commit    = 1'b0;
		ctrl      = '{we_rem: 1'b0, we_per: 1'b0, addr: idx_q,
			rem_data: unit_next, per_data: period_q};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					take = 1'b1;
					if (in_op == OP_ADD || count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ctrl.we_rem = 1'b1;
				if (last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				ctrl.addr = count_q[SLOT_W-1:0];
				if (res_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
					if (add_ok) begin
						commit      = 1'b1;
						ctrl.we_rem = 1'b1;
						ctrl.we_per = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= in_op;
			period_q <= PERIOD_WIDTH'(in_period);
			idx_q    <= '0;
			fired_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q          <= idx_q + SLOT_W'(1);
			fired_q[idx_q] <= unit_fire;
		end
	end

	always_comb begin
		res.accepted = add_ok;
		res.slot     = add_ok ? count_q[SLOT_W-1:0] : '0;
		res.fired    = (op_q == OP_TICK) ? fired_q : '0;
		res.count    = add_ok ? (count_q + COUNT_W'(1)) : count_q;
	end

endmodule

// File: design/periodic_task_tick_table_unit.sv
// periodic tick table: an add goes from idle through the done state to the output register;
// a tick first scans the occupied slots, a new request is taken only once the last is done,
// and the scan is set by the single countdown unit, which visits one slot per cycle
// request ready only while the sequencer is idle; a finished word waits in the output register
// reset (arst_n low, asynchronous) empties the table and drops any pending response;
// slot registers keep no reset and are only read once written by an add
module periodic_task_tick_table_unit import ptt_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	ptt_in_if.sink  request,
	ptt_out_if.source response
);

	result_t                 res;
	logic                    res_valid;
	logic                    res_free;
	store_ctrl_t             ctrl;
	logic [PERIOD_WIDTH-1:0] rd_rem;
	logic [PERIOD_WIDTH-1:0] rd_per;
	logic [PERIOD_WIDTH-1:0] unit_rem;
	logic [PERIOD_WIDTH-1:0] unit_per;
	logic                    unit_fire;
	logic [PERIOD_WIDTH-1:0] unit_next;

	// output register state
	logic                  out_valid_q;
	logic                  accepted_q;
	logic [SLOT_IDX_W-1:0] slot_index_q;
	logic [FIRE_W-1:0]     fire_mask_q;
	logic [TASK_CNT_W-1:0] task_count_q;

	// the sequencer may load a new word when the register is empty or being drained
	assign res_free = !out_valid_q || response.ready;

	// control: idle/scan/done sequencing, occupied count, fire mask build-up
	ptt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_op     (request.operation),
		.in_period (request.period_ticks),
		.in_ready  (request.ready),
		.res_free  (res_free),
		.res_valid (res_valid),
		.res       (res),
		.ctrl      (ctrl),
		.rd_rem    (rd_rem),
		.rd_per    (rd_per),
		.unit_rem  (unit_rem),
		.unit_per  (unit_per),
		.unit_fire (unit_fire),
		.unit_next (unit_next)
	);

	// per-slot period and countdown registers, one address per cycle
	ptt_slot_store u_store (
		.clk    (clk),
		.ctrl   (ctrl),
		.rd_rem (rd_rem),
		.rd_per (rd_per)
	);

	// the one decrement/reload unit, shared by ticks and adds
	ptt_count_unit u_unit (
		.rem  (unit_rem),
		.per  (unit_per),
		.fire (unit_fire),
		.next (unit_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// response fields cut or widened to their channel widths
	always_ff @(posedge clk) begin
		if (res_valid) begin
			accepted_q   <= res.accepted;
			slot_index_q <= SLOT_IDX_W'(res.slot);
			fire_mask_q  <= FIRE_W'(res.fired);
			task_count_q <= TASK_CNT_W'(res.count);
		end
	end

	assign response.valid      = out_valid_q;
	assign response.accepted   = accepted_q;
	assign response.slot_index = slot_index_q;
	assign response.fire_mask  = fire_mask_q;
	assign response.task_count = task_count_q;

endmodule

// File: design/ptt_checker.sv
// port-level checker of the periodic tick table and its bind
`include "periodic_task_tick_table_unit_defines.svh"

module ptt_checker import ptt_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  accepted,
	input logic [SLOT_IDX_W-1:0] slot_index,
	input logic [FIRE_W-1:0]     fire_mask,
	input logic [TASK_CNT_W-1:0] task_count
);

	logic                                   stalled;
	logic                                   added;
	logic                                   empty_seen;
	logic                                   quiet;
	logic [TASK_CNT_W-1:0]                  next_count;
	logic [SLOT_IDX_W+FIRE_W+TASK_CNT_W:0]  resp_word;

	assign stalled    = out_valid && !out_ready;
	assign added      = out_valid && accepted;
	assign empty_seen = out_valid && (task_count == '0);
	assign quiet      = (fire_mask == '0) && !accepted;
	assign next_count = TASK_CNT_W'(slot_index) + TASK_CNT_W'(1);
	assign resp_word  = {accepted, slot_index, fire_mask, task_count};

	// a stalled response word holds
	`PTT_ASSERT_NEXT(a_hold, clk, arst_n, stalled, out_valid && $stable(resp_word), "word not held")

	// an accepted add takes the slot just past the previous occupancy
	`PTT_ASSERT_NOW(a_slot, clk, arst_n, added, task_count == next_count, "slot/count mismatch")

	// an add never reports fired slots
	`PTT_ASSERT_NOW(a_add_mask, clk, arst_n, added, fire_mask == '0, "fire mask set on an add")

	// with an empty table nothing can fire
	`PTT_ASSERT_NOW(a_empty, clk, arst_n, empty_seen, quiet, "activity with an empty table")

endmodule

bind periodic_task_tick_table_unit ptt_checker u_ptt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (response.valid),
	.out_ready  (response.ready),
	.accepted   (response.accepted),
	.slot_index (response.slot_index),
	.fire_mask  (response.fire_mask),
	.task_count (response.task_count)
);

// File: test/periodic_task_tick_table_unit_test.sv
// self-checking bench for the periodic tick table: random adds and ticks against a predicted table
`timescale 1ns / 1ps

module periodic_task_tick_table_unit_test;
	import ptt_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int DRAIN_CYCLES  = 4 * (2 + NUM_SLOTS);
	localparam int RANDOM_WORDS  = 1000;
	localparam int PRESSURE_AT   = 150;
	localparam int PRESSURE_LEN  = 400;

	// one request word as queued for the driver, with the idle gap that follows it
	typedef struct {
		logic                   operation;
		logic [PERIOD_IN_W-1:0] period_ticks;
		int                     gap;
	} task_word_t;

	// one response word as predicted
	typedef struct {
		logic                  accepted;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [FIRE_W-1:0]     fire_mask;
		logic [TASK_CNT_W-1:0] task_count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ptt_in_if  request_ch ();
	ptt_out_if response_ch ();

	periodic_task_tick_table_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request_ch),
		.response (response_ch)
	);

	// predicted table: periods, countdowns and occupancy
	logic [PERIOD_WIDTH-1:0] period_copy [NUM_SLOTS];
	logic [PERIOD_WIDTH-1:0] countdown_copy [NUM_SLOTS];
	int unsigned             tasks_held = 0;

	task_word_t    pending_words [$];
	table_result_t expected_results [$];
	task_word_t    on_offer;
	table_result_t want;

	int idle_left = 0;
	int hold_left = 0;
	int results_seen = 0;
	int fail_count = 0;
	int cycle_count = 0;
	bit pressure_done = 1'b0;

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// applies one accepted word to the predicted table and gives the expected response
	function automatic table_result_t apply_to_table(input task_word_t w);
		table_result_t           r;
		logic [PERIOD_WIDTH-1:0] per;
		r.accepted   = 1'b0;
		r.slot_index = '0;
		r.fire_mask  = '0;
		per = w.period_ticks[PERIOD_WIDTH-1:0];
		if (w.operation == OP_ADD) begin
			// full table or zero period: rejected, nothing changes
			if (tasks_held < NUM_SLOTS && per != '0) begin
				period_copy[tasks_held]    = per;
				countdown_copy[tasks_held] = per - 1'b1;
				r.accepted   = 1'b1;
				r.slot_index = SLOT_IDX_W'(tasks_held);
				tasks_held++;
			end
		end else begin
			// only occupied slots are visited, so unwritten entries are never read
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (i < tasks_held) begin
					if (countdown_copy[i] == '0) begin
						r.fire_mask[i]    = 1'b1;
						countdown_copy[i] = period_copy[i] - 1'b1;
					end else begin
						countdown_copy[i] = countdown_copy[i] - 1'b1;
					end
				end
			end
		end
		r.task_count = TASK_CNT_W'(tasks_held);
		return r;
	endfunction

	task automatic queue_word(input logic op, input logic [PERIOD_IN_W-1:0] per, input int gap);
		task_word_t w;
		w.operation    = op;
		w.period_ticks = per;
		w.gap          = gap;
		pending_words.push_back(w);
	endtask

	// driver: offers queued words, holds each until the handshake takes it
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_ch.valid        <= 1'b0;
			request_ch.operation    <= OP_TICK;
			request_ch.period_ticks <= '0;
			idle_left = 0;
		end else begin
			// word taken at this edge: predict its response now
			if (request_ch.valid && request_ch.ready)
				expected_results.push_back(apply_to_table(on_offer));
			// free to change the offer only when nothing is waiting to be taken
			if (!request_ch.valid || request_ch.ready) begin
				if (idle_left > 0 || pending_words.size() == 0) begin
					if (idle_left > 0)
						idle_left--;
					request_ch.valid <= 1'b0;
				end else begin
					on_offer = pending_words.pop_front();
					request_ch.valid        <= 1'b1;
					request_ch.operation    <= on_offer.operation;
					request_ch.period_ticks <= on_offer.period_ticks;
					idle_left = on_offer.gap;
				end
			end
		end
	end

	// monitor: takes response words, compares against the oldest prediction, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			response_ch.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (response_ch.valid && response_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("response word with no prediction waiting");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (response_ch.accepted !== want.accepted) begin
						$error("accepted: expected %0d, actual %0d",
							want.accepted, response_ch.accepted);
						fail_count++;
					end
					if (response_ch.slot_index !== want.slot_index) begin
						$error("slot_index: expected %0d, actual %0d",
							want.slot_index, response_ch.slot_index);
						fail_count++;
					end
					if (response_ch.fire_mask !== want.fire_mask) begin
						$error("fire_mask: expected 0x%02h, actual 0x%02h",
							want.fire_mask, response_ch.fire_mask);
						fail_count++;
					end
					if (response_ch.task_count !== want.task_count) begin
						$error("task_count: expected %0d, actual %0d",
							want.task_count, response_ch.task_count);
						fail_count++;
					end
				end
				results_seen++;
			end
			// one long hold-off so the output register fills and the request side backs up
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				hold_left = PRESSURE_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				response_ch.ready <= 1'b0;
			end else begin
				response_ch.ready <= 1'b1;
				// every third stretch of results runs with no stalls
				if (((results_seen / 128) % 3) != 2)
					hold_left = pick_gap();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int  r;
		bit  calm;
		logic op;
		logic [PERIOD_IN_W-1:0] per;

		request_ch.valid        = 1'b0;
		request_ch.operation    = OP_TICK;
		request_ch.period_ticks = '0;
		response_ch.ready       = 1'b0;

		// directed: empty table, zero period, period of one, extremes, bit patterns, full table
		queue_word(OP_TICK, 16'hFFFF, pick_gap());   // tick on an empty table, period ignored
		queue_word(OP_ADD,  16'h0000, pick_gap());   // zero period, rejected
		queue_word(OP_ADD,  16'h0001, pick_gap());   // period of one, fires every tick
		queue_word(OP_TICK, 16'h0000, pick_gap());
		queue_word(OP_TICK, 16'h0000, pick_gap());
		queue_word(OP_ADD,  16'hFFFF, pick_gap());   // largest period
		queue_word(OP_ADD,  16'h0002, pick_gap());
		queue_word(OP_ADD,  16'h0003, pick_gap());
		repeat (4)
			queue_word(OP_TICK, 16'hAAAA, pick_gap());
		queue_word(OP_ADD,  16'h0005, pick_gap());
		queue_word(OP_ADD,  16'h0000, pick_gap());   // zero period with room left
		queue_word(OP_ADD,  16'h5555, pick_gap());
		queue_word(OP_ADD,  16'(($urandom_range(1, 12))), pick_gap());
		queue_word(OP_ADD,  16'(($urandom_range(1, 12))), pick_gap());
		queue_word(OP_ADD,  16'h0009, pick_gap());   // table full, rejected
		queue_word(OP_ADD,  16'h0000, pick_gap());   // full and zero period
		queue_word(OP_ADD,  16'hAAAA, pick_gap());   // full, other bit pattern
		repeat (5)
			queue_word(OP_TICK, 16'h5555, pick_gap());

		// random: mostly ticks, so the small periods keep firing in varied combinations
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			calm = ((k / 100) % 3) == 1;
			r = $urandom_range(0, 99);
			op = (r < 70) ? OP_TICK : OP_ADD;
			r = $urandom_range(0, 99);
			if (r < 40)
				per = 16'($urandom_range(0, 8));
			else if (r < 50)
				per = '0;
			else
				per = 16'($urandom_range(0, 65535));
			queue_word(op, per, calm ? 0 : pick_gap());
		end

		// reset held low from the start, released at an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every word to be taken, then for every response
		while (pending_words.size() != 0 || request_ch.valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// catch any stray word after the last one
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
